/* sv/rc4_pkg.sv */
// rc4_pkg: shared constants for the rc4 stream cipher engine
// sizes of the key store and permutation, beat codes and status codes
// no dependencies
package rc4_pkg;

  localparam int KEY_MAX    = 256;
  localparam int KEY_AW     = $clog2(KEY_MAX);
  localparam int PERM_SIZE  = 256;
  localparam int PERM_AW    = $clog2(PERM_SIZE);
  localparam int BYTE_W     = 8;
  localparam int KEY_LEN_W  = 9;
  localparam int KEY_LEN_RESET = 40;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_KEY   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCHED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DATA    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

endpackage

/* sv/rc4_stream_cipher.sv */
// rc4_stream_cipher: rc4 engine with key store, key schedule and keystream generator
// depends on rc4_pkg and rc4_ram
//
// usage
//   input stream: tuser carries the kind, tdata the key index, key byte and data byte.
//   a key-byte beat writes the key store as it is taken and returns nothing.
//   a schedule beat fills the permutation with the identity, then runs the key schedule
//   through ST_KA, ST_KB, ST_KC and ST_KD for each index over the one read port and one
//   write port of the permutation ram and returns one done beat with a zero byte.
//   a data beat after a schedule returns data xor keystream through ST_J, ST_K and
//   ST_FIN, set by the read of s[i], the read of s[j] and the keystream read through the
//   one read port of the permutation ram; ST_FIN takes the next beat if the output is free.
//   a data beat before any schedule comes back unchanged with the refused status.
//   key_length is set through cfg_we/cfg_wdata, by the user only while idle; the block
//   does not enforce this. 0 acts as 1, above 256 as 256.
//   reset clears the key store (valid bits), both indices, the keyed flag and
//   sets key_length to 40. the permutation needs no clearing.
//   a stalled receiver holds the result in the output register; one more result
//   can wait in a hold register, after which the input stops taking beats.
module rc4_stream_cipher (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rc4_pkg::KEY_LEN_W-1:0]       cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,  // key_index, key_byte, data_byte
  input  logic [rc4_pkg::KIND_W-1:0]          s_axis_tuser,  // kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rc4_pkg::BYTE_W-1:0]          m_axis_tdata,  // out_byte
  output logic [rc4_pkg::STATUS_W-1:0]        m_axis_tuser   // status
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_J, ST_K, ST_FIN, ST_HOLD, ST_INIT, ST_KA, ST_KB, ST_KC, ST_KD
  } state_t;

  localparam logic [rc4_pkg::PERM_AW-1:0] LAST_IDX = rc4_pkg::PERM_AW'(rc4_pkg::PERM_SIZE - 1);

  state_t state;

  logic [rc4_pkg::KEY_LEN_W-1:0] key_length;
  logic [rc4_pkg::KEY_LEN_W-1:0] len_eff;
  logic [rc4_pkg::KEY_MAX-1:0]   key_valid;
  logic                          key_vld_q;
  logic [rc4_pkg::KEY_AW-1:0]    k;
  logic [rc4_pkg::KEY_AW-1:0]    k_next;
  logic [rc4_pkg::KEY_LEN_W-1:0] k_inc;

  logic [rc4_pkg::PERM_AW-1:0] i;
  logic [rc4_pkg::PERM_AW-1:0] j;
  logic [rc4_pkg::BYTE_W-1:0]  a;
  logic [rc4_pkg::BYTE_W-1:0]  b;
  logic [rc4_pkg::BYTE_W-1:0]  data;
  logic                        keyed;
  logic                        fwd;
  logic                        hit_i;
  logic                        hit_j;

  logic [rc4_pkg::BYTE_W-1:0]   hold_byte;
  logic [rc4_pkg::STATUS_W-1:0] hold_status;

  logic [rc4_pkg::KIND_W-1:0] in_kind;
  logic [rc4_pkg::KEY_AW-1:0] in_key_index;
  logic [rc4_pkg::BYTE_W-1:0] in_key_byte;
  logic [rc4_pkg::BYTE_W-1:0] in_data_byte;

  logic in_acc;
  logic can_load;

  logic                        perm_we;
  logic [rc4_pkg::PERM_AW-1:0] perm_waddr;
  logic [rc4_pkg::BYTE_W-1:0]  perm_wdata;
  logic [rc4_pkg::PERM_AW-1:0] perm_raddr;
  logic [rc4_pkg::BYTE_W-1:0]  perm_rdata;

  logic                       key_we;
  logic [rc4_pkg::KEY_AW-1:0] key_raddr;
  logic [rc4_pkg::BYTE_W-1:0] key_rdata;
  logic [rc4_pkg::BYTE_W-1:0] key_val;

  logic [rc4_pkg::BYTE_W-1:0] a_cur;
  logic [rc4_pkg::BYTE_W-1:0] sched_j;
  logic [rc4_pkg::BYTE_W-1:0] ks;

  assign in_key_index = s_axis_tdata[7:0];
  assign in_key_byte  = s_axis_tdata[15:8];
  assign in_data_byte = s_axis_tdata[23:16];
  assign in_kind      = s_axis_tuser;

  assign can_load      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) || ((state == ST_FIN) && can_load);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (key_length == '0) begin
      len_eff = rc4_pkg::KEY_LEN_W'(1);
    end else if (key_length > rc4_pkg::KEY_LEN_W'(rc4_pkg::KEY_MAX)) begin
      len_eff = rc4_pkg::KEY_LEN_W'(rc4_pkg::KEY_MAX);
    end else begin
      len_eff = key_length;
    end
  end

  assign k_inc  = {1'b0, k} + rc4_pkg::KEY_LEN_W'(1);
  assign k_next = (k_inc >= len_eff) ? '0 : k_inc[rc4_pkg::KEY_AW-1:0];

  assign key_val = key_vld_q ? key_rdata : '0;
  assign a_cur   = fwd ? a : perm_rdata;
  assign sched_j = j + perm_rdata + key_val;
  assign ks      = hit_j ? a : (hit_i ? b : perm_rdata);

  assign key_we    = in_acc && (in_kind == rc4_pkg::KIND_KEY);
  assign key_raddr = key_we ? in_key_index : k;

  always_comb begin
    perm_we    = 1'b0;
    perm_waddr = i;
    perm_wdata = perm_rdata;
    perm_raddr = i;
    case (state)
      ST_J: begin
        perm_raddr = j + a_cur;
      end
      ST_K: begin
        perm_we    = 1'b1;
        perm_waddr = i;
        perm_wdata = perm_rdata;
        perm_raddr = a + perm_rdata;
      end
      ST_FIN: begin
        perm_we    = 1'b1;
        perm_waddr = j;
        perm_wdata = a;
      end
      ST_INIT: begin
        perm_we    = 1'b1;
        perm_waddr = i;
        perm_wdata = i;
      end
      ST_KB: begin
        perm_raddr = sched_j;
      end
      ST_KC: begin
        perm_we    = 1'b1;
        perm_waddr = i;
        perm_wdata = perm_rdata;
      end
      ST_KD: begin
        perm_we    = 1'b1;
        perm_waddr = j;
        perm_wdata = a;
      end
      default: begin
        perm_we = 1'b0;
      end
    endcase
    if (in_acc && (in_kind == rc4_pkg::KIND_DATA) && keyed) begin
      perm_raddr = i + rc4_pkg::PERM_AW'(1);
    end
  end

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (rc4_pkg::PERM_SIZE)
  ) u_perm (
    .clk   (clk),
    .we    (perm_we),
    .waddr (perm_waddr),
    .wdata (perm_wdata),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (rc4_pkg::KEY_MAX)
  ) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_key_index),
    .wdata (in_key_byte),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      key_length    <= rc4_pkg::KEY_LEN_W'(rc4_pkg::KEY_LEN_RESET);
      key_valid     <= '0;
      i             <= '0;
      j             <= '0;
      keyed         <= 1'b0;
      fwd           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      key_vld_q <= key_valid[k];
      if (cfg_we) begin
        key_length <= cfg_wdata;
      end
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          state <= ST_IDLE;
        end
        ST_J: begin
          a     <= a_cur;
          j     <= j + a_cur;
          fwd   <= 1'b0;
          state <= ST_K;
        end
        ST_K: begin
          b     <= perm_rdata;
          hit_i <= ((a + perm_rdata) == i);
          hit_j <= ((a + perm_rdata) == j);
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (can_load) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= data ^ ks;
            m_axis_tuser  <= rc4_pkg::STATUS_DATA;
            state         <= ST_IDLE;
          end else begin
            hold_byte   <= data ^ ks;
            hold_status <= rc4_pkg::STATUS_DATA;
            state       <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (can_load) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= hold_byte;
            m_axis_tuser  <= hold_status;
            state         <= ST_IDLE;
          end
        end
        ST_INIT: begin
          i <= i + rc4_pkg::PERM_AW'(1);
          if (i == LAST_IDX) begin
            k     <= '0;
            j     <= '0;
            state <= ST_KA;
          end
        end
        ST_KA: begin
          state <= ST_KB;
        end
        ST_KB: begin
          a     <= perm_rdata;
          j     <= sched_j;
          state <= ST_KC;
        end
        ST_KC: begin
          state <= ST_KD;
        end
        ST_KD: begin
          k <= k_next;
          i <= i + rc4_pkg::PERM_AW'(1);
          if (i == LAST_IDX) begin
            j     <= '0;
            keyed <= 1'b1;
            if (can_load) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata  <= '0;
              m_axis_tuser  <= rc4_pkg::STATUS_DONE;
              state         <= ST_IDLE;
            end else begin
              hold_byte   <= '0;
              hold_status <= rc4_pkg::STATUS_DONE;
              state       <= ST_HOLD;
            end
          end else begin
            state <= ST_KA;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (in_acc) begin
        case (in_kind)
          rc4_pkg::KIND_KEY: begin
            key_valid[in_key_index] <= 1'b1;
            state                   <= ST_IDLE;
          end
          rc4_pkg::KIND_SCHED: begin
            i     <= '0;
            state <= ST_INIT;
          end
          rc4_pkg::KIND_DATA: begin
            if (keyed) begin
              data  <= in_data_byte;
              i     <= i + rc4_pkg::PERM_AW'(1);
              fwd   <= (state == ST_FIN) && ((i + rc4_pkg::PERM_AW'(1)) == j);
              state <= ST_J;
            end else if ((state == ST_IDLE) && can_load) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata  <= in_data_byte;
              m_axis_tuser  <= rc4_pkg::STATUS_REFUSED;
              state         <= ST_IDLE;
            end else begin
              hold_byte   <= in_data_byte;
              hold_status <= rc4_pkg::STATUS_REFUSED;
              state       <= ST_HOLD;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_hold_has_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> m_axis_tvalid)
    else $error("hold state entered with an empty output register");

  a_data_path: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_kind == rc4_pkg::KIND_DATA) && keyed)
      |=> (state == ST_J) ##1 (state == ST_K) ##1 (state == ST_FIN))
    else $error("keyed data beat did not follow the three-cycle path");

  a_sched_keys: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_KD) && (i == LAST_IDX)) |=> (keyed && (i == '0) && (j == '0)))
    else $error("end of key schedule did not set keyed and clear indices");

  a_fwd_origin: assert property (@(posedge clk) disable iff (rst)
    fwd |-> ((state == ST_J) && $past(state == ST_FIN)))
    else $error("forwarding flag set outside a back-to-back data beat");
`endif

endmodule

/* sv/rc4_ram.sv */
// rc4_ram: generic single-clock ram, one write port and one registered read port
// a read at the address being written returns the old contents
// no dependencies
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
